FILE: hw/rtl/wavdac_pkg.sv
// ----------------------------------------------------------------------------
// wavdac_pkg: shared types and constants for the WAV stream to DAC block
// Chunk ids, field constants, result kinds and the queue entry layout that
// passes between the parser front end and the sample back end.
// ----------------------------------------------------------------------------
package wavdac_pkg;

	// Chunk ids as seen in a little-endian 4-byte window
	localparam logic [31:0] ID_RIFF = 32'h4646_4952;
	localparam logic [31:0] ID_FMT  = 32'h2074_6d66;
	localparam logic [31:0] ID_DATA = 32'h6174_6164;

	// fmt chunk size that carries an extra-length field
	localparam logic [31:0] FMT_EXTRA_SIZE = 32'd18;
	// DAC resolution; deeper samples are shifted down to it
	localparam logic [15:0] DAC_BITS = 16'd12;
	// Largest sample width in bytes
	localparam logic [2:0] MAX_SAMPLE_BYTES = 3'd4;

	// Volume register
	localparam int unsigned GAIN_W = 4;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 4'd4;

	// Default depth of the queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;

	// Result kinds
	localparam logic KIND_HEADER = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	// One classified result waiting for the back end
	typedef struct packed {
		logic        kind;
		logic [31:0] sample;
		logic [4:0]  shift;
		logic        zero;
		logic        last;
		logic [31:0] rate;
		logic [15:0] depth;
		logic [15:0] channels;
		logic [15:0] format;
		logic [31:0] data_bytes;
	} wavdac_item_t;

endpackage

FILE: hw/rtl/wav_stream_to_dac_samples.sv
// A result beat enters the queue when the file byte that completes it is accepted, then moves to the output register.
// The input takes one file byte per cycle while the queue is not full; each byte gives at most one result beat.
// A queue of FIFO_DEPTH entries lets the byte input run while the result sink stalls;
// input ready drops only when that queue is full.
// Reset clears the parser to the start of a file and sets the volume gain to 4;
// a byte flagged as start of file restarts parsing without touching the gain.
// ----------------------------------------------------------------------------
// wav_stream_to_dac_samples: WAV byte stream to scaled DAC samples
// Parses RIFF/fmt/data chunks from a byte stream, emits one header beat at the
// start of the data chunk and then one scaled sample beat per sample.
// ----------------------------------------------------------------------------
module wav_stream_to_dac_samples
	import wavdac_pkg::*;
#(
	parameter int unsigned FIFO_DEPTH = QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	// Configuration: volume gain
	input  logic              cfg_we,
	input  logic [GAIN_W-1:0] cfg_wdata,
	// File byte input
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [7:0]        s_axis_tdata,   // [7:0] file_byte
	input  logic [0:0]        s_axis_tuser,   // [0] start_of_file
	// Result output
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [127:0]      m_axis_tdata,   // [15:0] dac_value, [47:16] sample_rate,
	                                          // [63:48] bit_depth, [79:64] channel_count,
	                                          // [95:80] format_code, [127:96] data_bytes
	output logic [0:0]        m_axis_tuser,   // [0] result_kind
	output logic              m_axis_tlast    // last
);

	logic         push;
	wavdac_item_t push_item;
	logic         full;
	logic         pop;
	wavdac_item_t head_item;
	logic         empty;

	assign s_axis_tready = !full;

	wavdac_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.in_sof    (s_axis_tuser[0]),
		.push      (push),
		.push_item (push_item)
	);

	wavdac_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.pop_item  (head_item),
		.empty     (empty)
	);

	wavdac_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.head_valid (!empty),
		.head_item  (head_item),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_data   (m_axis_tdata),
		.out_kind   (m_axis_tuser[0]),
		.out_last   (m_axis_tlast)
	);

`ifndef SYNTHESIS
	// Push only on an accepted beat, never into a full queue
	a_push_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (s_axis_tvalid && s_axis_tready && !full))
		else $error("queue push without an accepted input beat");

	// Pop only from a non-empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue pop while empty");

	// A header item never carries the last mark
	a_last_on_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_item.last) |-> (push_item.kind == KIND_SAMPLE))
		else $error("last mark on a header item");

	// A stalled output beat is not replaced
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |-> !pop)
		else $error("output beat overwritten while stalled");
`endif

endmodule

FILE: hw/rtl/wavdac_front.sv
// ----------------------------------------------------------------------------
// wavdac_front: WAV header parser and sample gatherer
// Takes one file byte per beat, tracks the chunk structure, captures the fmt
// fields and data size, and gathers sample bytes. Each beat pushes at most
// one classified item into the queue.
// ----------------------------------------------------------------------------
module wavdac_front
	import wavdac_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic         in_ready,
	input  logic [7:0]   in_byte,
	input  logic         in_sof,
	output logic         push,
	output wavdac_item_t push_item
);

	typedef enum logic [2:0] {
		PH_SEEK,
		PH_RIFF,
		PH_FMT,
		PH_XLEN,
		PH_XSKIP,
		PH_DSIZE,
		PH_SAMPLES,
		PH_DONE
	} phase_t;

	// Place byte k of a little-endian field; byte zero starts the field anew
	function automatic logic [31:0] put32(input logic [31:0] r, input logic [7:0] b,
			input logic [1:0] k);
		logic [31:0] ext;
		ext = {24'd0, b};
		if (k == 2'd0)
			return ext;
		return r | (ext << {k, 3'b000});
	endfunction

	function automatic logic [15:0] put16(input logic [15:0] r, input logic [7:0] b,
			input logic k);
		if (!k)
			return {8'd0, b};
		return r | {b, 8'd0};
	endfunction

	phase_t      phase_q;
	logic [31:0] window_q;
	logic        fmt_seen_q;
	logic [4:0]  fcount_q;
	logic [15:0] skip_q;
	logic [1:0]  align_q;
	logic [31:0] rate_q;
	logic [15:0] depth_q;
	logic [15:0] chan_q;
	logic [15:0] format_q;
	logic [31:0] fmt_size_q;
	logic [31:0] dsize_q;
	logic [31:0] rem_q;
	logic [31:0] accum_q;
	logic [1:0]  sidx_q;

	phase_t      c_phase, n_phase;
	logic [31:0] c_window, n_window;
	logic        c_fmt_seen, n_fmt_seen;
	logic [4:0]  c_fcount, n_fcount;
	logic [15:0] c_skip, n_skip;
	logic [1:0]  c_align, n_align;
	logic [31:0] c_rate, n_rate;
	logic [15:0] c_depth, n_depth;
	logic [15:0] c_chan, n_chan;
	logic [15:0] c_format, n_format;
	logic [31:0] c_fmt_size, n_fmt_size;
	logic [31:0] c_dsize, n_dsize;
	logic [31:0] c_rem, n_rem;
	logic [31:0] c_accum, n_accum;
	logic [1:0]  c_sidx, n_sidx;

	logic        accept;
	logic [12:0] depth_bytes;
	logic [2:0]  bps;
	logic [15:0] depth_excess;
	logic [4:0]  shift;
	logic        shift_zero;

	assign accept = in_valid && in_ready;

	// Start of file clears the parse state before this byte is used
	always_comb begin
		c_phase    = in_sof ? PH_SEEK : phase_q;
		c_window   = in_sof ? '0 : window_q;
		c_fmt_seen = in_sof ? 1'b0 : fmt_seen_q;
		c_fcount   = in_sof ? '0 : fcount_q;
		c_skip     = in_sof ? '0 : skip_q;
		c_align    = in_sof ? '0 : align_q;
		c_rate     = in_sof ? '0 : rate_q;
		c_depth    = in_sof ? '0 : depth_q;
		c_chan     = in_sof ? '0 : chan_q;
		c_format   = in_sof ? '0 : format_q;
		c_fmt_size = in_sof ? '0 : fmt_size_q;
		c_dsize    = in_sof ? '0 : dsize_q;
		c_rem      = in_sof ? '0 : rem_q;
		c_accum    = in_sof ? '0 : accum_q;
		c_sidx     = in_sof ? '0 : sidx_q;
	end

	// Bytes per sample and the shift down to DAC resolution
	always_comb begin
		depth_bytes = c_depth[15:3];
		if (depth_bytes == 13'd0)
			bps = 3'd1;
		else if (depth_bytes > 13'(MAX_SAMPLE_BYTES))
			bps = MAX_SAMPLE_BYTES;
		else
			bps = depth_bytes[2:0];
		depth_excess = c_depth - DAC_BITS;
		if (c_depth >= DAC_BITS) begin
			shift      = depth_excess[4:0];
			shift_zero = (depth_excess[15:5] != 11'd0);
		end else begin
			shift      = '0;
			shift_zero = 1'b0;
		end
	end

	// Parse one byte
	always_comb begin
		n_phase    = c_phase;
		n_window   = {in_byte, c_window[31:8]};
		n_fmt_seen = c_fmt_seen;
		n_fcount   = c_fcount;
		n_skip     = c_skip;
		n_align    = c_align;
		n_rate     = c_rate;
		n_depth    = c_depth;
		n_chan     = c_chan;
		n_format   = c_format;
		n_fmt_size = c_fmt_size;
		n_dsize    = c_dsize;
		n_rem      = c_rem;
		n_accum    = c_accum;
		n_sidx     = c_sidx;
		push       = 1'b0;
		push_item  = '0;

		unique case (c_phase)
			PH_SEEK: begin
				if (c_align != 2'd3)
					n_align = c_align + 2'd1;
				else if (!c_fmt_seen)
					n_align = '0;
				if (c_align == 2'd3) begin
					if (n_window == ID_FMT) begin
						n_fmt_seen = 1'b1;
						n_phase    = PH_FMT;
						n_fcount   = '0;
					end else if (n_window == ID_RIFF) begin
						n_phase  = PH_RIFF;
						n_fcount = '0;
					end else if (n_window == ID_DATA) begin
						n_phase  = PH_DSIZE;
						n_fcount = '0;
					end
				end
			end
			PH_RIFF: begin
				if (c_fcount >= 5'd7) begin
					n_phase  = PH_SEEK;
					n_align  = '0;
					n_fcount = '0;
				end else begin
					n_fcount = c_fcount + 5'd1;
				end
			end
			PH_FMT: begin
				if (c_fcount < 5'd4)
					n_fmt_size = put32(c_fmt_size, in_byte, c_fcount[1:0]);
				else if (c_fcount < 5'd6)
					n_format = put16(c_format, in_byte, c_fcount[0]);
				else if (c_fcount < 5'd8)
					n_chan = put16(c_chan, in_byte, c_fcount[0]);
				else if (c_fcount < 5'd12)
					n_rate = put32(c_rate, in_byte, c_fcount[1:0]);
				else if (c_fcount >= 5'd18)
					n_depth = put16(c_depth, in_byte, c_fcount[0]);
				if (c_fcount >= 5'd19) begin
					if (n_fmt_size == FMT_EXTRA_SIZE) begin
						n_phase  = PH_XLEN;
						n_fcount = '0;
					end else begin
						n_phase  = PH_SEEK;
						n_align  = '0;
						n_fcount = '0;
					end
				end else begin
					n_fcount = c_fcount + 5'd1;
				end
			end
			PH_XLEN: begin
				n_skip = put16(c_skip, in_byte, c_fcount != 5'd0);
				if (c_fcount != 5'd0) begin
					if (n_skip == 16'd0) begin
						n_phase  = PH_SEEK;
						n_align  = '0;
						n_fcount = '0;
					end else begin
						n_phase = PH_XSKIP;
					end
				end else begin
					n_fcount = 5'd1;
				end
			end
			PH_XSKIP: begin
				if (c_skip != 16'd0)
					n_skip = c_skip - 16'd1;
				if (n_skip == 16'd0) begin
					n_phase  = PH_SEEK;
					n_align  = '0;
					n_fcount = '0;
				end
			end
			PH_DSIZE: begin
				n_dsize = put32(c_dsize, in_byte, c_fcount[1:0]);
				if (c_fcount < 5'd3) begin
					n_fcount = c_fcount + 5'd1;
				end else begin
					n_fcount = '0;
					n_rem    = n_dsize;
					n_sidx   = '0;
					n_accum  = '0;
					n_phase  = (n_dsize == 32'd0) ? PH_DONE : PH_SAMPLES;
					push                 = accept;
					push_item.kind       = KIND_HEADER;
					push_item.rate       = c_rate;
					push_item.depth      = c_depth;
					push_item.channels   = c_chan;
					push_item.format     = c_format;
					push_item.data_bytes = n_dsize;
				end
			end
			PH_SAMPLES: begin
				n_accum = put32(c_accum, in_byte, c_sidx);
				n_rem   = c_rem - 32'd1;
				if (({1'b0, c_sidx} + 3'd1) >= bps) begin
					n_sidx           = '0;
					push             = accept;
					push_item.kind   = KIND_SAMPLE;
					push_item.sample = n_accum;
					push_item.shift  = shift;
					push_item.zero   = shift_zero;
					push_item.last   = (n_rem < {29'd0, bps});
				end else begin
					n_sidx = c_sidx + 2'd1;
				end
				if (n_rem == 32'd0)
					n_phase = PH_DONE;
			end
			PH_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// Hold parse state; advance on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SEEK;
			window_q   <= '0;
			fmt_seen_q <= 1'b0;
			fcount_q   <= '0;
			skip_q     <= '0;
			align_q    <= '0;
			rate_q     <= '0;
			depth_q    <= '0;
			chan_q     <= '0;
			format_q   <= '0;
			fmt_size_q <= '0;
			dsize_q    <= '0;
			rem_q      <= '0;
			accum_q    <= '0;
			sidx_q     <= '0;
		end else if (accept) begin
			phase_q    <= n_phase;
			window_q   <= n_window;
			fmt_seen_q <= n_fmt_seen;
			fcount_q   <= n_fcount;
			skip_q     <= n_skip;
			align_q    <= n_align;
			rate_q     <= n_rate;
			depth_q    <= n_depth;
			chan_q     <= n_chan;
			format_q   <= n_format;
			fmt_size_q <= n_fmt_size;
			dsize_q    <= n_dsize;
			rem_q      <= n_rem;
			accum_q    <= n_accum;
			sidx_q     <= n_sidx;
		end
	end

endmodule

FILE: hw/rtl/wavdac_fifo.sv
// ----------------------------------------------------------------------------
// wavdac_fifo: item queue between parser and sample back end
// Small register-based FIFO; the head entry is visible without delay.
// ----------------------------------------------------------------------------
module wavdac_fifo
	import wavdac_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  wavdac_item_t push_item,
	output logic         full,
	input  logic         pop,
	output wavdac_item_t pop_item,
	output logic         empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	wavdac_item_t   mem_q [DEPTH];
	logic [AW-1:0]  wptr_q;
	logic [AW-1:0]  rptr_q;
	logic [CW-1:0]  count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_item = mem_q[rptr_q];

	// Store the pushed entry
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= push_item;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			if (pop)
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

FILE: hw/rtl/wavdac_back.sv
// ----------------------------------------------------------------------------
// wavdac_back: sample scaling and output register
// Shifts each gathered sample to DAC resolution, applies the volume gain and
// holds the result beat until the sink takes it.
// ----------------------------------------------------------------------------
module wavdac_back
	import wavdac_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [GAIN_W-1:0] cfg_wdata,
	input  logic              head_valid,
	input  wavdac_item_t      head_item,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [127:0]      out_data,
	output logic              out_kind,
	output logic              out_last
);

	logic [GAIN_W-1:0]  gain_q;
	logic               valid_q;
	logic [127:0]       data_q;
	logic               kind_q;
	logic               last_q;
	logic [31:0]        shifted;
	logic [GAIN_W+15:0] product;
	logic [15:0]        dac;

	assign pop       = head_valid && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_data  = data_q;
	assign out_kind  = kind_q;
	assign out_last  = last_q;

	// Scale the head sample
	always_comb begin
		shifted = head_item.zero ? 32'd0 : (head_item.sample >> head_item.shift);
		product = {{GAIN_W{1'b0}}, shifted[15:0]} * {16'd0, gain_q};
		dac     = (head_item.kind == KIND_SAMPLE) ? product[15:0] : 16'd0;
	end

	// Hold the volume gain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			gain_q <= GAIN_RESET;
		else if (cfg_we)
			gain_q <= cfg_wdata;
	end

	// Load the output beat when empty or taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= {head_item.data_bytes, head_item.format, head_item.channels,
				head_item.depth, head_item.rate, dac};
			kind_q <= head_item.kind;
			last_q <= head_item.last;
		end
	end

endmodule

FILE: verif/tb_wav_stream_to_dac_samples.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wav_stream_to_dac_samples: self-checking bench for the WAV to DAC block
// Feeds WAV byte streams (a short table of hand-checked rows, then random
// well-formed, truncated and noisy files) through the byte input under random
// bursts and sink stalls. A local parser model predicts every header and
// sample beat; beats are compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_wav_stream_to_dac_samples;
	import wavdac_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES   = 8;
	localparam int unsigned LONG_HOLD      = 300;
	localparam int unsigned PHASE_BYTES    = 48;
	localparam logic [31:0] ID_LIST        = 32'h5453_494c;

	// One result beat as seen on the output
	typedef struct packed {
		logic        kind;
		logic [15:0] dac_value;
		logic [31:0] sample_rate;
		logic [15:0] bit_depth;
		logic [15:0] channel_count;
		logic [15:0] format_code;
		logic [31:0] data_bytes;
		logic        last;
	} dac_beat_t;

	// One file byte to send, optionally with a hand-written expectation
	typedef struct packed {
		logic      [7:0] octet;
		logic            new_file;
		logic            fixed;
		logic            fixed_has;
		dac_beat_t       fixed_beat;
	} file_byte_t;

	typedef enum logic [2:0] {
		STEP_SEEK_ID, STEP_RIFF_SKIP, STEP_FMT_FIELDS, STEP_EXTRA_LEN,
		STEP_EXTRA_SKIP, STEP_DATA_SIZE, STEP_AUDIO, STEP_DONE
	} parse_step_t;

	localparam dac_beat_t NO_BEAT = '0;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              cfg_we        = 1'b0;
	logic [GAIN_W-1:0] cfg_wdata     = '0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [7:0]        s_axis_tdata  = '0;
	logic [0:0]        s_axis_tuser  = '0;   // [0] start_of_file
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [127:0]      m_axis_tdata;         // [15:0] dac_value, [47:16] sample_rate,
	                                         // [63:48] bit_depth, [79:64] channel_count,
	                                         // [95:80] format_code, [127:96] data_bytes
	logic [0:0]        m_axis_tuser;         // [0] result_kind
	logic              m_axis_tlast;

	wav_stream_to_dac_samples i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Hand-checked rows: a data chunk with no fmt (one byte per sample, gain 4),
	// then a zero-size data chunk, with ignored bytes after each
	file_byte_t directed_rows [22] = '{
		'{8'h64, 1'b1, 1'b0, 1'b0, NO_BEAT},
		'{8'h61, 1'b0, 1'b0, 1'b0, NO_BEAT},
		'{8'h74, 1'b0, 1'b0, 1'b0, NO_BEAT},
		'{8'h61, 1'b0, 1'b0, 1'b0, NO_BEAT},
		'{8'h03, 1'b0, 1'b0, 1'b0, NO_BEAT},
		'{8'h00, 1'b0, 1'b0, 1'b0, NO_BEAT},
		'{8'h00, 1'b0, 1'b0, 1'b0, NO_BEAT},
		'{8'h00, 1'b0, 1'b1, 1'b1,
			'{KIND_HEADER, 16'h0000, 32'd0, 16'd0, 16'd0, 16'd0, 32'd3, 1'b0}},
		'{8'hff, 1'b0, 1'b1, 1'b1,
			'{KIND_SAMPLE, 16'h03fc, 32'd0, 16'd0, 16'd0, 16'd0, 32'd0, 1'b0}},
		'{8'h00, 1'b0, 1'b1, 1'b1,
			'{KIND_SAMPLE, 16'h0000, 32'd0, 16'd0, 16'd0, 16'd0, 32'd0, 1'b0}},
		'{8'h80, 1'b0, 1'b1, 1'b1,
			'{KIND_SAMPLE, 16'h0200, 32'd0, 16'd0, 16'd0, 16'd0, 32'd0, 1'b1}},
		'{8'hff, 1'b0, 1'b1, 1'b0, NO_BEAT},
		'{8'h64, 1'b1, 1'b0, 1'b0, NO_BEAT},
		'{8'h61, 1'b0, 1'b0, 1'b0, NO_BEAT},
		'{8'h74, 1'b0, 1'b0, 1'b0, NO_BEAT},
		'{8'h61, 1'b0, 1'b0, 1'b0, NO_BEAT},
		'{8'h00, 1'b0, 1'b0, 1'b0, NO_BEAT},
		'{8'h00, 1'b0, 1'b0, 1'b0, NO_BEAT},
		'{8'h00, 1'b0, 1'b0, 1'b0, NO_BEAT},
		'{8'h00, 1'b0, 1'b1, 1'b1,
			'{KIND_HEADER, 16'h0000, 32'd0, 16'd0, 16'd0, 16'd0, 32'd0, 1'b0}},
		'{8'h55, 1'b0, 1'b1, 1'b0, NO_BEAT},
		'{8'haa, 1'b0, 1'b1, 1'b0, NO_BEAT}
	};

	file_byte_t  byte_plan [$];
	dac_beat_t   pending_beats [$];
	logic [7:0]  file_bytes [$];
	int          error_count = 0;
	bit          hold_request = 1'b0;

	// Parser model state
	logic [3:0]   gain_q;
	logic [31:0]  win_q;
	parse_step_t  step_q;
	bit           fmt_found;
	int unsigned  field_idx;
	logic [15:0]  extra_left;
	logic [1:0]   group_pos;
	logic [31:0]  rate_q, depth_q, chans_q, fmt_code_q, fmt_len_q;
	logic [31:0]  data_len_q, data_seen, acc_q;
	logic [1:0]   acc_idx;

	function automatic void clear_parser();
		win_q = '0; step_q = STEP_SEEK_ID; fmt_found = 1'b0;
		field_idx = 0; extra_left = '0; group_pos = '0;
		rate_q = '0; depth_q = '0; chans_q = '0; fmt_code_q = '0; fmt_len_q = '0;
		data_len_q = '0; data_seen = '0; acc_q = '0; acc_idx = '0;
	endfunction

	function automatic void restart_id_search();
		step_q = STEP_SEEK_ID;
		group_pos = '0;
		field_idx = 0;
	endfunction

	// Little-endian field assembly; byte 0 starts the field anew
	function automatic logic [31:0] merge_le(input logic [31:0] old, input logic [7:0] b,
		input int unsigned k);
		if (k == 0)
			return {24'd0, b};
		return old | ({24'd0, b} << (8 * (k % 4)));
	endfunction

	function automatic logic [31:0] sample_width_bytes(input logic [31:0] depth);
		logic [31:0] n;
		n = depth / 8;
		if (n < 1)
			n = 1;
		if (n > MAX_SAMPLE_BYTES)
			n = MAX_SAMPLE_BYTES;
		return n;
	endfunction

	// Advance the parser by one byte; return 1 with the beat when one is due
	function automatic bit predict_beat(input logic [7:0] b, input logic new_file,
		output dac_beat_t beat);
		int unsigned k;
		logic [31:0] bps, s, sh, prod;
		bit hit;
		beat = '0;
		hit = 1'b0;
		if (new_file)
			clear_parser();
		win_q = {b, win_q[31:8]};
		k = field_idx;
		case (step_q)
			STEP_SEEK_ID: begin
				if (group_pos == 2'd3) begin
					// aligned groups until fmt, sliding search afterwards
					if (!fmt_found)
						group_pos = '0;
					if (win_q == ID_FMT) begin
						fmt_found = 1'b1; step_q = STEP_FMT_FIELDS; field_idx = 0;
					end else if (win_q == ID_RIFF) begin
						step_q = STEP_RIFF_SKIP; field_idx = 0;
					end else if (win_q == ID_DATA) begin
						step_q = STEP_DATA_SIZE; field_idx = 0;
					end
				end else begin
					group_pos = group_pos + 2'd1;
				end
			end
			STEP_RIFF_SKIP: begin
				if (k >= 7)
					restart_id_search();
				else
					field_idx = k + 1;
			end
			STEP_FMT_FIELDS: begin
				if (k < 4)
					fmt_len_q = merge_le(fmt_len_q, b, k);
				else if (k < 6)
					fmt_code_q = merge_le(fmt_code_q, b, k - 4);
				else if (k < 8)
					chans_q = merge_le(chans_q, b, k - 6);
				else if (k < 12)
					rate_q = merge_le(rate_q, b, k - 8);
				else if (k >= 18)
					depth_q = merge_le(depth_q, b, k - 18);
				if (k >= 19) begin
					if (fmt_len_q == FMT_EXTRA_SIZE) begin
						step_q = STEP_EXTRA_LEN; field_idx = 0;
					end else begin
						restart_id_search();
					end
				end else begin
					field_idx = k + 1;
				end
			end
			STEP_EXTRA_LEN: begin
				extra_left = 16'(merge_le({16'd0, extra_left}, b, k));
				if (k >= 1) begin
					if (extra_left == 0)
						restart_id_search();
					else
						step_q = STEP_EXTRA_SKIP;
				end else begin
					field_idx = 1;
				end
			end
			STEP_EXTRA_SKIP: begin
				if (extra_left > 0)
					extra_left = extra_left - 16'd1;
				if (extra_left == 0)
					restart_id_search();
			end
			STEP_DATA_SIZE: begin
				data_len_q = merge_le(data_len_q, b, k);
				if (k < 3) begin
					field_idx = k + 1;
				end else begin
					field_idx = 0; data_seen = '0; acc_idx = '0; acc_q = '0;
					step_q = (data_len_q == 0) ? STEP_DONE : STEP_AUDIO;
					beat.kind          = KIND_HEADER;
					beat.sample_rate   = rate_q;
					beat.bit_depth     = depth_q[15:0];
					beat.channel_count = chans_q[15:0];
					beat.format_code   = fmt_code_q[15:0];
					beat.data_bytes    = data_len_q;
					hit = 1'b1;
				end
			end
			STEP_AUDIO: begin
				bps = sample_width_bytes(depth_q);
				acc_q = merge_le(acc_q, b, acc_idx);
				data_seen = data_seen + 1;
				if (acc_idx + 32'd1 >= bps) begin
					// scale deep samples down to DAC resolution, then apply gain
					s = acc_q;
					if (depth_q >= DAC_BITS) begin
						sh = depth_q - DAC_BITS;
						s = (sh >= 32) ? 32'd0 : (s >> sh);
					end
					prod = gain_q * s[15:0];
					beat.kind      = KIND_SAMPLE;
					beat.dac_value = prod[15:0];
					beat.last      = ((data_len_q - data_seen) < bps);
					acc_idx = '0;
					hit = 1'b1;
				end else begin
					acc_idx = acc_idx + 2'd1;
				end
				if (data_seen >= data_len_q)
					step_q = STEP_DONE;
			end
			default: ;
		endcase
		return hit;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			error_count++;
		end
	endfunction

	// Byte source: bursts of random length with random gaps
	int         gap_left = 0;
	int         burst_left = 0;
	file_byte_t on_bus = '0;

	always @(posedge clk) begin : byte_source
		dac_beat_t beat;
		bit        has;
		bit        fire;
		bit        load;
		if (arst_n) begin
			fire = s_axis_tvalid && s_axis_tready;
			if (fire) begin
				// predict on every accepted beat; hand-checked rows override
				has = predict_beat(on_bus.octet, on_bus.new_file, beat);
				if (on_bus.fixed) begin
					if (on_bus.fixed_has)
						pending_beats.push_back(on_bus.fixed_beat);
				end else if (has) begin
					pending_beats.push_back(beat);
				end
			end
			if (!s_axis_tvalid || fire) begin
				load = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (byte_plan.size() > 0) begin
					on_bus = byte_plan.pop_front();
					load = 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
				s_axis_tvalid <= load;
				s_axis_tdata  <= on_bus.octet;
				s_axis_tuser  <= on_bus.new_file;
			end
		end
	end

	// Result sink: check each beat, stall on a changing pattern
	int sink_mode = 0;
	int mode_left = 0;
	int sink_tick = 0;
	int hold_left = 0;

	always @(posedge clk) begin : result_sink
		dac_beat_t want;
		bit        ready_nxt;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_beats.size() == 0) begin
					$error("result beat with nothing expected");
					error_count++;
				end else begin
					want = pending_beats.pop_front();
					check_field("result_kind", want.kind, m_axis_tuser[0]);
					check_field("dac_value", want.dac_value, m_axis_tdata[15:0]);
					check_field("sample_rate", want.sample_rate, m_axis_tdata[47:16]);
					check_field("bit_depth", want.bit_depth, m_axis_tdata[63:48]);
					check_field("channel_count", want.channel_count, m_axis_tdata[79:64]);
					check_field("format_code", want.format_code, m_axis_tdata[95:80]);
					check_field("data_bytes", want.data_bytes, m_axis_tdata[127:96]);
					check_field("last", want.last, m_axis_tlast);
				end
			end
			if (mode_left == 0) begin
				sink_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 80);
			end else begin
				mode_left--;
			end
			sink_tick++;
			if (hold_left > 0) begin
				hold_left--;
				ready_nxt = 1'b0;
			end else if (hold_request && m_axis_tvalid) begin
				// hold off long enough for the block to fill and stall its input
				hold_left = LONG_HOLD;
				hold_request = 1'b0;
				ready_nxt = 1'b0;
			end else begin
				case (sink_mode)
					0:       ready_nxt = 1'b1;
					1:       ready_nxt = (sink_tick[1:0] != 2'd0);
					2:       ready_nxt = $urandom_range(0, 1);
					default: ready_nxt = (sink_tick[1:0] == 2'd0);
				endcase
			end
			m_axis_tready <= ready_nxt;
		end
	end

	// End the run when neither side has moved a beat for too long
	int quiet_cycles = 0;

	always @(posedge clk) begin : watchdog
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_wav_stream_to_dac_samples: errors");
			$finish;
		end
	end

	task automatic push_le(input logic [31:0] v, input int n);
		for (int i = 0; i < n; i++)
			file_bytes.push_back(v[8*i +: 8]);
	endtask

	task automatic push_random(input int n);
		for (int i = 0; i < n; i++)
			file_bytes.push_back($urandom_range(0, 255));
	endtask

	// Build one WAV file with random content; cut it short when broken
	task automatic queue_wav_file(input int min_samples, input bit broken);
		logic [31:0] depth, fmt_len, bps, dsize;
		int          xlen, keep;
		file_byte_t  item;
		file_bytes.delete();
		if ($urandom_range(0, 4) != 0) begin
			push_le(ID_RIFF, 4);
			push_random(8);
		end
		// unknown chunk on aligned groups before fmt
		if ($urandom_range(0, 3) == 0) begin
			push_le(ID_LIST, 4);
			push_random(4 * $urandom_range(0, 2));
		end
		case ($urandom_range(0, 9))
			0:          fmt_len = $urandom_range(0, 40);
			1, 2, 3, 4: fmt_len = 32'd18;
			default:    fmt_len = 32'd16;
		endcase
		case ($urandom_range(0, 7))
			0:       depth = $urandom_range(0, 7);
			1:       depth = 8;
			2:       depth = 12;
			3:       depth = 16;
			4:       depth = 24;
			5:       depth = 32;
			6:       depth = $urandom_range(33, 43);
			default: depth = $urandom_range(44, 65535);
		endcase
		push_le(ID_FMT, 4);
		push_le(fmt_len, 4);
		push_le(($urandom_range(0, 3) != 0) ? 32'd1 : $urandom_range(0, 65535), 2);
		push_le(($urandom_range(0, 3) != 0) ? $urandom_range(1, 2) : $urandom_range(0, 65535),
			2);
		push_le($urandom, 4);
		push_random(6);
		push_le(depth, 2);
		if (fmt_len == FMT_EXTRA_SIZE) begin
			xlen = $urandom_range(0, 3);
			push_le(xlen, 2);
			push_random(xlen);
		end
		// unknown chunk seen by the sliding search
		if ($urandom_range(0, 3) == 0) begin
			push_le(ID_LIST, 4);
			push_random($urandom_range(0, 6));
		end
		bps = sample_width_bytes(depth);
		dsize = bps * $urandom_range(min_samples, min_samples + 5);
		if (bps > 1 && $urandom_range(0, 3) == 0)
			dsize = dsize + $urandom_range(1, bps - 1);
		push_le(ID_DATA, 4);
		push_le(dsize, 4);
		for (int i = 0; i < dsize; i++)
			file_bytes.push_back(($urandom_range(0, 7) == 0) ? 8'hff : $urandom_range(0, 255));
		if ($urandom_range(0, 3) == 0)
			push_random($urandom_range(1, 4));
		keep = broken ? $urandom_range(1, file_bytes.size() - 1) : file_bytes.size();
		for (int i = 0; i < keep; i++) begin
			item = '0;
			item.octet = file_bytes[i];
			item.new_file = (i == 0);
			byte_plan.push_back(item);
		end
	endtask

	// Wait until every byte is taken, every beat is checked and the pipe is empty
	task automatic drain_phase();
		while (byte_plan.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin : main_seq
		logic [3:0] gain_steps [6];
		logic [3:0] next_gain;
		file_byte_t item;
		int         phase_start;
		int         pick;
		gain_steps = '{4'd15, 4'd0, 4'd7, 4'd1, 4'd15, 4'd9};
		clear_parser();
		gain_q = GAIN_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed rows at the reset gain
		foreach (directed_rows[i])
			byte_plan.push_back(directed_rows[i]);
		drain_phase();

		for (int p = 0; p < 6; p++) begin
			// write the gain while the block is idle
			next_gain = (p == 2 || p == 5) ? 4'($urandom_range(0, 15)) : gain_steps[p];
			gain_q = next_gain;
			@(posedge clk);
			cfg_we    <= 1'b1;
			cfg_wdata <= next_gain;
			@(posedge clk);
			cfg_we <= 1'b0;
			@(posedge clk);

			phase_start = byte_plan.size();
			if (p == 2) begin
				hold_request = 1'b1;
				queue_wav_file(16, 1'b0);
			end
			while (byte_plan.size() - phase_start < PHASE_BYTES) begin
				pick = $urandom_range(0, 19);
				if (pick < 15) begin
					queue_wav_file(0, 1'b0);
				end else if (pick < 18) begin
					queue_wav_file(0, 1'b1);
				end else begin
					// loose noise bytes with the occasional restart
					repeat ($urandom_range(1, 8)) begin
						item = '0;
						item.octet = $urandom_range(0, 255);
						item.new_file = ($urandom_range(0, 5) == 0);
						byte_plan.push_back(item);
					end
				end
			end
			drain_phase();
		end

		if (error_count == 0 && pending_beats.size() == 0)
			$display("tb_wav_stream_to_dac_samples: clean");
		else
			$display("tb_wav_stream_to_dac_samples: errors");
		$finish;
	end

endmodule
